// File: sv/assert_macros.svh
// Assertion helpers shared by the date counter modules.
// Every check is clocked on clk and held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define CDC_ASSERT_ALWAYS(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// The consequence holds in the cycle after the antecedent.
`define CDC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/cdc_pkg.sv
package cdc_pkg;

	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int YearW  = 16;

	typedef logic [MonthW-1:0] month_t;
	typedef logic [DayW-1:0]   day_t;
	typedef logic [YearW-1:0]  year_t;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_FWD   = 2'd1,
		FUNC_BACK  = 2'd2,
		FUNC_QUERY = 2'd3
	} func_t;

	localparam month_t JAN = month_t'(1);
	localparam month_t FEB = month_t'(2);
	localparam month_t APR = month_t'(4);
	localparam month_t JUN = month_t'(6);
	localparam month_t SEP = month_t'(9);
	localparam month_t NOV = month_t'(11);
	localparam month_t DEC = month_t'(12);

	localparam day_t FIRST_DAY = day_t'(1);
	localparam day_t LEN_28    = day_t'(28);
	localparam day_t LEN_29    = day_t'(29);
	localparam day_t LEN_30    = day_t'(30);
	localparam day_t LEN_31    = day_t'(31);

	// Multiplying by the inverse of 25 modulo 2^16 maps exactly the multiples
	// of 25 onto the range 0 .. 65535/25.
	localparam year_t INV25     = year_t'(23593);
	localparam year_t DIV25_MAX = year_t'((2 ** YearW - 1) / 25);

	localparam month_t DEFAULT_MONTH = JAN;
	localparam day_t   DEFAULT_DAY   = FIRST_DAY;
	localparam year_t  DEFAULT_YEAR  = year_t'(1900);
	localparam year_t  DEFAULT_YINV  = year_t'((1900 * 23593) % (2 ** YearW));

	typedef struct packed {
		func_t  func;
		month_t month;
		day_t   day;
		year_t  year;
		year_t  yinv;
	} cmd_t;

	typedef struct packed {
		logic   load_rejected;
		day_t   month_length;
		logic   leap;
		year_t  new_year;
		day_t   new_day;
		month_t new_month;
		year_t  prev_year;
		day_t   prev_day;
		month_t prev_month;
	} result_t;

	localparam int FuncW     = 2;
	localparam int LoadW     = MonthW + DayW + YearW;
	localparam int S_TDATA_W = ((LoadW + 7) / 8) * 8;
	localparam int RESULT_W  = $bits(result_t);
	localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

	// Leap when divisible by 4, and either not by 25 or also by 16.
	function automatic logic leap_f(input year_t y, input year_t yinv);
		return (y[1:0] == 2'b00) && ((yinv > DIV25_MAX) || (y[3:0] == 4'b0000));
	endfunction

	function automatic day_t days_in_f(input month_t m, input logic leap);
		day_t len;
		if (m == FEB) begin
			len = leap ? LEN_29 : LEN_28;
		end else if (m == APR || m == JUN || m == SEP || m == NOV) begin
			len = LEN_30;
		end else begin
			len = LEN_31;
		end
		return len;
	endfunction

endpackage

// File: sv/cdc_in_stage.sv
`include "assert_macros.svh"

module cdc_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cdc_pkg::func_t  func,
	input  cdc_pkg::month_t load_month,
	input  cdc_pkg::day_t   load_day,
	input  cdc_pkg::year_t  load_year,
	input  logic            out_free,
	output logic            adv,
	output cdc_pkg::cmd_t   cmd_s1
);
	import cdc_pkg::*;

	logic  valid_s1;
	year_t yinv_d;

	// The load year is scaled here so the leap test later needs only a compare.
	assign yinv_d   = load_year * INV25;
	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1.func  <= func;
			cmd_s1.month <= load_month;
			cmd_s1.day   <= load_day;
			cmd_s1.year  <= load_year;
			cmd_s1.yinv  <= yinv_d;
		end
	end

	`CDC_ASSERT_NEXT(a_stall_holds, valid_s1 && !adv, valid_s1 && $stable(cmd_s1))

endmodule

// File: sv/cdc_date_core.sv
`include "assert_macros.svh"

module cdc_date_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  cdc_pkg::cmd_t    cmd_s1,
	output cdc_pkg::result_t res
);
	import cdc_pkg::*;

	month_t month_q, month_n;
	day_t   day_q, day_n;
	year_t  year_q, year_n;
	year_t  yinv_q, yinv_n;

	logic  leap_cur, leap_inc, leap_dec, leap_ld, leap_n, ld_ok, rejected;
	day_t  len_cur, len_ld;
	year_t year_inc, year_dec, yinv_inc, yinv_dec;

	assign leap_cur = leap_f(year_q, yinv_q);
	assign len_cur  = days_in_f(month_q, leap_cur);

	// The scaled year moves by the constant along with the year itself.
	assign year_inc = year_q + year_t'(1);
	assign yinv_inc = yinv_q + INV25;
	assign year_dec = year_q - year_t'(1);
	assign yinv_dec = yinv_q - INV25;
	assign leap_inc = leap_f(year_inc, yinv_inc);
	assign leap_dec = leap_f(year_dec, yinv_dec);

	assign leap_ld = leap_f(cmd_s1.year, cmd_s1.yinv);
	assign len_ld  = days_in_f(cmd_s1.month, leap_ld);
	assign ld_ok   = (cmd_s1.month >= JAN) && (cmd_s1.month <= DEC) &&
		(cmd_s1.day != '0) && (cmd_s1.day <= len_ld);

	always_comb begin
		month_n  = month_q;
		day_n    = day_q;
		year_n   = year_q;
		yinv_n   = yinv_q;
		leap_n   = leap_cur;
		rejected = 1'b0;
		unique case (cmd_s1.func)
			FUNC_LOAD: begin
				if (ld_ok) begin
					month_n = cmd_s1.month;
					day_n   = cmd_s1.day;
					year_n  = cmd_s1.year;
					yinv_n  = cmd_s1.yinv;
					leap_n  = leap_ld;
				end else begin
					month_n  = DEFAULT_MONTH;
					day_n    = DEFAULT_DAY;
					year_n   = DEFAULT_YEAR;
					yinv_n   = DEFAULT_YINV;
					leap_n   = leap_f(DEFAULT_YEAR, DEFAULT_YINV);
					rejected = 1'b1;
				end
			end
			FUNC_FWD: begin
				if (day_q >= len_cur) begin
					day_n = FIRST_DAY;
					if (month_q >= DEC) begin
						month_n = JAN;
						year_n  = year_inc;
						yinv_n  = yinv_inc;
						leap_n  = leap_inc;
					end else begin
						month_n = month_q + month_t'(1);
					end
				end else begin
					day_n = day_q + day_t'(1);
				end
			end
			FUNC_BACK: begin
				if (day_q <= FIRST_DAY) begin
					if (month_q <= JAN) begin
						month_n = DEC;
						day_n   = LEN_31;
						year_n  = year_dec;
						yinv_n  = yinv_dec;
						leap_n  = leap_dec;
					end else begin
						month_n = month_q - month_t'(1);
						day_n   = days_in_f(month_n, leap_cur);
					end
				end else begin
					day_n = day_q - day_t'(1);
				end
			end
			FUNC_QUERY: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.prev_month    = month_q;
		res.prev_day      = day_q;
		res.prev_year     = year_q;
		res.new_month     = month_n;
		res.new_day       = day_n;
		res.new_year      = year_n;
		res.leap          = leap_n;
		res.month_length  = days_in_f(month_n, leap_n);
		res.load_rejected = rejected;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			month_q <= DEFAULT_MONTH;
			day_q   <= DEFAULT_DAY;
			year_q  <= DEFAULT_YEAR;
			yinv_q  <= DEFAULT_YINV;
		end else if (adv) begin
			month_q <= month_n;
			day_q   <= day_n;
			year_q  <= year_n;
			yinv_q  <= yinv_n;
		end
	end

	`CDC_ASSERT_ALWAYS(a_month_range, month_q >= JAN && month_q <= DEC)
	`CDC_ASSERT_ALWAYS(a_day_range, day_q != '0 && day_q <= len_cur)
	`CDC_ASSERT_ALWAYS(a_yinv_track, yinv_q == YearW'(year_q * INV25))

endmodule

// File: sv/calendar_date_counter_unit.sv
// Path: a command beat accepted on the input is registered in the input stage (cmd_s1),
// then goes through the date core into the result register (res_s2) on the result bus.
// Throughput: one command per cycle unless m_axis_tready holds back the result;
// the date registers close their update loop through combinational next-state logic,
// and while the result register waits on m_axis_tready an empty input stage takes a beat.
// Reset: arst_n clears both stages and sets the held date to 1/1/1900.
`include "assert_macros.svh"

module calendar_date_counter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// load_month, load_day, load_year, zero fill
	input  logic [cdc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// func
	input  logic [cdc_pkg::FuncW-1:0]      s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// prev_month, prev_day, prev_year, new_month, new_day, new_year, leap,
	// month_length, load_rejected, zero fill
	output logic [cdc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import cdc_pkg::*;

	logic    adv, out_free, valid_s2;
	cmd_t    cmd_s1;
	result_t res, res_s2;

	assign out_free = !valid_s2 || m_axis_tready;

	cdc_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.func       (func_t'(s_axis_tuser)),
		.load_month (s_axis_tdata[MonthW-1:0]),
		.load_day   (s_axis_tdata[MonthW+DayW-1:MonthW]),
		.load_year  (s_axis_tdata[LoadW-1:MonthW+DayW]),
		.out_free   (out_free),
		.adv        (adv),
		.cmd_s1     (cmd_s1)
	);

	cdc_date_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cmd_s1 (cmd_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	// The result struct is declared with its first field in the highest bits.
	assign m_axis_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, res_s2};

	`CDC_ASSERT_NEXT(a_adv_shows, adv, m_axis_tvalid)
	`CDC_ASSERT_ALWAYS(a_out_day_fits, !valid_s2 || res_s2.new_day <= res_s2.month_length)

endmodule
